FILE: hw/rtl/shadow_slot_allocator_defines.svh
// Assertion macros for the slot allocator RTL (used by ssa_ctrl).
`ifndef SHADOW_SLOT_ALLOCATOR_DEFINES_SVH
`define SHADOW_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSA_CHECK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSA_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ssa_pkg.sv
// Types and constants shared by the slot allocator modules.
package ssa_pkg;

    localparam int SLOT_W    = 6;
    localparam int STATUS_W  = 3;
    localparam int MODE_W    = 2;
    localparam int LIMIT_W   = 7;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int OUT_RANGE = 64;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd8;

    // Register index taken from paddr[2]
    localparam logic REG_SLOT_LIMIT = 1'b0;

    // Request modes (any mode with bit 1 set clears the stack and the fresh counter)
    localparam logic [MODE_W-1:0] MODE_ACQUIRE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_REUSED       = 3'd0,
        ST_FRESH        = 3'd1,
        ST_EXHAUSTED    = 3'd2,
        ST_RELEASED     = 3'd3,
        ST_OUT_OF_RANGE = 3'd4,
        ST_FULL         = 3'd5,
        ST_RESET        = 3'd6
    } t_status;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        t_status           status;
    } t_result;

endpackage

FILE: hw/rtl/shadow_slot_allocator.sv
// Slot allocator top level: register port, sequencer, stack memory, output stage.
//
// Use: each request word (i_mode, i_slot_in) on the i_valid/o_stall channel
// yields exactly one result word (o_slot_out, o_status) on o_valid/i_stall.
// Mode 0 acquires a slot (reuse from the free stack, else a fresh index,
// else exhausted with slot 0), mode 1 releases i_slot_in, modes 2 and 3
// clear the stack and the fresh counter.
// Each result is registered in the sequencer and then loaded into the output
// register; an acquire served from the stack first reads its entry through
// the stack memory's registered read port.
// Requests are taken one per cycle while the result channel does not stall,
// except that a stack acquire holds off the next request during that read.
// Register slot_limit (byte address 0) is written over the APB-style port
// and reads back; it may be written only while the block is idle.
// Reset (i_rst_n low, synchronous) empties the stack, clears the fresh
// counter, drops any pending result and sets slot_limit to 8.
// When the receiver stalls, the output word holds; one more request may
// be taken and its result parked, after which o_stall rises.
module shadow_slot_allocator #(
    parameter int SLOT_CAPACITY = 64,
    localparam int AW = $clog2(SLOT_CAPACITY)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [ssa_pkg::MODE_W-1:0]    i_mode,
    input  logic [ssa_pkg::SLOT_W-1:0]    i_slot_in,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [ssa_pkg::SLOT_W-1:0]    o_slot_out,
    output logic [ssa_pkg::STATUS_W-1:0]  o_status,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ssa_pkg::PADDR_W-1:0]   paddr,
    input  logic [ssa_pkg::PDATA_W-1:0]   pwdata,
    output logic [ssa_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [ssa_pkg::LIMIT_W-1:0] r_slot_limit;
    logic                        cfg_write;

    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [ssa_pkg::SLOT_W-1:0]  mem_wdata;
    logic                        mem_re;
    logic [AW-1:0]               mem_raddr;
    logic [ssa_pkg::SLOT_W-1:0]  mem_rdata;

    logic                        res_valid;
    ssa_pkg::t_result            res;
    logic                        res_ready;
    ssa_pkg::t_result            out_res;

    // Register write and readback
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_limit <= ssa_pkg::LIMIT_RESET;
        end else if (cfg_write && (paddr[2] == ssa_pkg::REG_SLOT_LIMIT)) begin
            r_slot_limit <= pwdata[ssa_pkg::LIMIT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == ssa_pkg::REG_SLOT_LIMIT) ?
                    ssa_pkg::PDATA_W'(r_slot_limit) : '0;

    ssa_ctrl #(
        .SLOT_CAPACITY (SLOT_CAPACITY)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_mode       (i_mode),
        .i_slot_in    (i_slot_in),
        .o_stall      (o_stall),
        .i_slot_limit (r_slot_limit),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (res_ready)
    );

    ssa_stack_mem #(
        .DEPTH (SLOT_CAPACITY)
    ) u_stack_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ssa_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (out_res)
    );

    assign o_slot_out = out_res.slot;
    assign o_status   = out_res.status;

endmodule

FILE: hw/rtl/ssa_stack_mem.sv
// Free-slot stack storage: one write port, one read port, registered read data.
module ssa_stack_mem #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [ssa_pkg::SLOT_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [ssa_pkg::SLOT_W-1:0] o_rdata
);

    logic [ssa_pkg::SLOT_W-1:0] r_mem [DEPTH];
    logic [ssa_pkg::SLOT_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/ssa_out_reg.sv
// Output register stage for result words.
module ssa_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_res_valid,
    input  ssa_pkg::t_result i_res,
    output logic             o_res_ready,
    output logic             o_valid,
    input  logic             i_stall,
    output ssa_pkg::t_result o_res
);

    logic             r_valid;
    ssa_pkg::t_result r_res;
    logic             load;

    // Take a new word when empty or when the current one leaves
    assign o_res_ready = !r_valid || !i_stall;
    assign load        = i_res_valid && o_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Payload holds while stalled
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

FILE: hw/rtl/ssa_ctrl.sv
// Request sequencer: stack pointer, fresh counter and stack push/pop control.
`include "shadow_slot_allocator_defines.svh"

module ssa_ctrl #(
    parameter int SLOT_CAPACITY = 64,
    localparam int AW = $clog2(SLOT_CAPACITY),
    localparam int DW = $clog2(SLOT_CAPACITY + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_valid,
    input  logic [ssa_pkg::MODE_W-1:0]  i_mode,
    input  logic [ssa_pkg::SLOT_W-1:0]  i_slot_in,
    output logic                        o_stall,
    // configuration
    input  logic [ssa_pkg::LIMIT_W-1:0] i_slot_limit,
    // stack memory
    output logic                        o_mem_we,
    output logic [AW-1:0]               o_mem_waddr,
    output logic [ssa_pkg::SLOT_W-1:0]  o_mem_wdata,
    output logic                        o_mem_re,
    output logic [AW-1:0]               o_mem_raddr,
    input  logic [ssa_pkg::SLOT_W-1:0]  i_mem_rdata,
    // result toward output stage
    output logic                        o_res_valid,
    output ssa_pkg::t_result            o_res,
    input  logic                        i_res_ready
);

    localparam int LIM_CAP = (SLOT_CAPACITY < ssa_pkg::OUT_RANGE) ?
                             SLOT_CAPACITY : ssa_pkg::OUT_RANGE;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                        r_state,     n_state;
    logic [DW-1:0]                 r_depth,     n_depth;
    logic [ssa_pkg::LIMIT_W-1:0]   r_fresh,     n_fresh;
    logic                          r_res_valid, n_res_valid;
    ssa_pkg::t_result              r_res,       n_res;

    logic                          core_ready;
    logic                          accept;
    logic [ssa_pkg::LIMIT_W-1:0]   eff_limit;
    logic [DW-1:0]                 depth_dec;

    // Saturate the limit to capacity and to the slot range
    assign eff_limit = (i_slot_limit > ssa_pkg::LIMIT_W'(LIM_CAP)) ?
                       ssa_pkg::LIMIT_W'(LIM_CAP) : i_slot_limit;

    // Take a request only when idle and the result slot frees up
    assign core_ready = (r_state == S_IDLE) && (!r_res_valid || i_res_ready);
    assign accept     = i_valid && core_ready;
    assign o_stall    = !core_ready;

    assign depth_dec  = r_depth - DW'(1);

    // Decode request, drive memory and compute next state
    always_comb begin
        n_state     = r_state;
        n_depth     = r_depth;
        n_fresh     = r_fresh;
        n_res_valid = r_res_valid && !i_res_ready;
        n_res       = r_res;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_depth[AW-1:0];
        o_mem_wdata = i_slot_in;
        o_mem_re    = 1'b0;
        o_mem_raddr = depth_dec[AW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res_valid = 1'b1;
                    n_res.slot  = '0;
                    unique case (i_mode)
                        ssa_pkg::MODE_ACQUIRE: begin
                            if (r_depth != '0) begin
                                // pop: fetch top entry, finish next cycle
                                o_mem_re    = 1'b1;
                                n_depth     = depth_dec;
                                n_res_valid = 1'b0;
                                n_state     = S_READ;
                            end else if (r_fresh >= eff_limit) begin
                                n_res.status = ssa_pkg::ST_EXHAUSTED;
                            end else begin
                                n_res.slot   = r_fresh[ssa_pkg::SLOT_W-1:0];
                                n_res.status = ssa_pkg::ST_FRESH;
                                n_fresh      = r_fresh + ssa_pkg::LIMIT_W'(1);
                            end
                        end
                        ssa_pkg::MODE_RELEASE: begin
                            if ({1'b0, i_slot_in} >= eff_limit) begin
                                n_res.status = ssa_pkg::ST_OUT_OF_RANGE;
                            end else if (r_depth >= DW'(SLOT_CAPACITY)) begin
                                n_res.status = ssa_pkg::ST_FULL;
                            end else begin
                                o_mem_we     = 1'b1;
                                n_depth      = r_depth + DW'(1);
                                n_res.status = ssa_pkg::ST_RELEASED;
                            end
                        end
                        default: begin
                            // clear stack and counter
                            n_depth      = '0;
                            n_fresh      = '0;
                            n_res.status = ssa_pkg::ST_RESET;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res_valid  = 1'b1;
                n_res.slot   = i_mem_rdata;
                n_res.status = ssa_pkg::ST_REUSED;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_fresh     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_depth     <= n_depth;
            r_fresh     <= n_fresh;
            r_res_valid <= n_res_valid;
        end
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    `SSA_CHECK(a_depth_bound, i_clk, i_rst_n, 1'b1, r_depth <= DW'(SLOT_CAPACITY), "stack depth beyond capacity")
    `SSA_CHECK(a_fresh_bound, i_clk, i_rst_n, 1'b1, r_fresh <= ssa_pkg::LIMIT_W'(LIM_CAP), "fresh counter beyond limit")
    `SSA_CHECK(a_read_empty, i_clk, i_rst_n, r_state == S_READ, !r_res_valid, "pending result during stack read")
    `SSA_CHECK_NEXT(a_read_done, i_clk, i_rst_n, r_state == S_READ, r_res_valid && (r_res.status == ssa_pkg::ST_REUSED) && (r_state == S_IDLE), "stack read did not complete")

endmodule

FILE: tb/sv/tb_shadow_slot_allocator.sv
// Self-checking testbench for the slot allocator: directed and random request words, scoreboard prediction.
module tb_shadow_slot_allocator;

    localparam int CAPACITY = 64;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [ssa_pkg::MODE_W-1:0] MODE_CLEAR     = 2'd2;
    localparam logic [ssa_pkg::MODE_W-1:0] MODE_CLEAR_ALT = 2'd3;

    // Track free indices and the fresh counter, queue the expected result words
    class slot_scoreboard;
        logic [ssa_pkg::SLOT_W-1:0]  free_slots [CAPACITY];
        int                          stack_depth;
        int                          fresh_next;
        logic [ssa_pkg::LIMIT_W-1:0] slot_limit;
        ssa_pkg::t_result            expected_grants [$];
        int                          errors;

        function new();
            stack_depth = 0;
            fresh_next  = 0;
            slot_limit  = ssa_pkg::LIMIT_RESET;
            errors      = 0;
        endfunction

        function void set_limit(input logic [ssa_pkg::LIMIT_W-1:0] value);
            slot_limit = value;
        endfunction

        // Saturate the limit to the stack capacity and to the range of slot_out
        function int usable_limit();
            int lim;
            lim = int'(slot_limit);
            if (lim > CAPACITY) lim = CAPACITY;
            if (lim > ssa_pkg::OUT_RANGE) lim = ssa_pkg::OUT_RANGE;
            return lim;
        endfunction

        function ssa_pkg::t_result predict_grant(
            input logic [ssa_pkg::MODE_W-1:0] mode,
            input logic [ssa_pkg::SLOT_W-1:0] slot);
            ssa_pkg::t_result r;
            int               lim;
            lim    = usable_limit();
            r.slot = '0;
            if (mode == ssa_pkg::MODE_ACQUIRE) begin
                if (stack_depth > 0) begin
                    stack_depth--;
                    r.slot   = free_slots[stack_depth];
                    r.status = ssa_pkg::ST_REUSED;
                end else if (fresh_next >= lim) begin
                    r.status = ssa_pkg::ST_EXHAUSTED;
                end else begin
                    r.slot   = ssa_pkg::SLOT_W'(fresh_next);
                    fresh_next++;
                    r.status = ssa_pkg::ST_FRESH;
                end
            end else if (mode == ssa_pkg::MODE_RELEASE) begin
                if (int'(slot) >= lim) begin
                    r.status = ssa_pkg::ST_OUT_OF_RANGE;
                end else if (stack_depth >= CAPACITY) begin
                    r.status = ssa_pkg::ST_FULL;
                end else begin
                    free_slots[stack_depth] = slot;
                    stack_depth++;
                    r.status = ssa_pkg::ST_RELEASED;
                end
            end else begin
                stack_depth = 0;
                fresh_next  = 0;
                r.status    = ssa_pkg::ST_RESET;
            end
            return r;
        endfunction

        function void note_request(input logic [ssa_pkg::MODE_W-1:0] mode,
                                   input logic [ssa_pkg::SLOT_W-1:0] slot);
            ssa_pkg::t_result want;
            want            = predict_grant(mode, slot);
            expected_grants = {expected_grants, want};
        endfunction

        function void check_result(input logic [ssa_pkg::SLOT_W-1:0]   slot,
                                   input logic [ssa_pkg::STATUS_W-1:0] status);
            ssa_pkg::t_result want;
            if (expected_grants.size() == 0) begin
                $error("unexpected result word: slot_out %0d status %0d", slot, status);
                errors++;
                return;
            end
            want = expected_grants.pop_front();
            if (slot !== want.slot) begin
                $error("slot_out mismatch: expected %0d, actual %0d", want.slot, slot);
                errors++;
            end
            if (status !== want.status) begin
                $error("status mismatch: expected %0d (%s), actual %0d",
                       want.status, want.status.name(), status);
                errors++;
            end
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [ssa_pkg::MODE_W-1:0]   i_mode;
    logic [ssa_pkg::SLOT_W-1:0]   i_slot_in;
    logic                         o_valid;
    logic                         i_stall;
    logic [ssa_pkg::SLOT_W-1:0]   o_slot_out;
    logic [ssa_pkg::STATUS_W-1:0] o_status;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [ssa_pkg::PADDR_W-1:0]  paddr;
    logic [ssa_pkg::PDATA_W-1:0]  pwdata;
    logic [ssa_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    slot_scoreboard sb = new();

    int idle_pct;
    int stall_pct;
    int hold_cycles;
    int words_sent;

    shadow_slot_allocator u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_mode     (i_mode),
        .i_slot_in  (i_slot_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_slot_out (o_slot_out),
        .o_status   (o_status),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Free-running clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Watchdog on the whole run
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Note accepted request words, check accepted result words
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_request(i_mode, i_slot_in);
            if (o_valid && !i_stall) sb.check_result(o_slot_out, o_status);
        end
    end

    // Drive receiver stall: a counted hold-off first, else random at the set rate
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                i_stall <= 1'b1;
                hold_cycles--;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        idle_pct  = send_pct;
        stall_pct = recv_pct;
    endtask

    // Offer one request word after idle cycles at the set rate, hold it until taken
    task automatic send_word(input logic [ssa_pkg::MODE_W-1:0] mode,
                             input logic [ssa_pkg::SLOT_W-1:0] slot);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_mode    <= mode;
        i_slot_in <= slot;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
    endtask

    // Stop offering and wait until every expected word has come back
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write slot_limit: setup cycle, then access cycle until pready
    task automatic write_limit(input logic [ssa_pkg::LIMIT_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ssa_pkg::REG_SLOT_LIMIT, 2'b00};
        pwdata  <= ssa_pkg::PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_limit(value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Pick an index the block will accept, or any index when the limit is zero
    function automatic logic [ssa_pkg::SLOT_W-1:0] in_range_index();
        int lim;
        lim = sb.usable_limit();
        if (lim == 0) return ssa_pkg::SLOT_W'($urandom_range(63));
        return ssa_pkg::SLOT_W'($urandom_range(lim - 1));
    endfunction

    // Mostly well-formed acquire and release runs, some clears and some noise
    task automatic run_mix(input int count);
        int stop;
        int kind;
        int n;
        stop = words_sent + count;
        while (words_sent < stop) begin
            kind = $urandom_range(99);
            if (kind < 30) begin
                n = $urandom_range(1, 12);
                repeat (n) send_word(ssa_pkg::MODE_ACQUIRE,
                                     ssa_pkg::SLOT_W'($urandom_range(63)));
            end else if (kind < 50) begin
                n = $urandom_range(1, 16);
                repeat (n) send_word(ssa_pkg::MODE_RELEASE, in_range_index());
            end else if (kind < 70) begin
                n = $urandom_range(1, 20);
                repeat (n) begin
                    if ($urandom_range(1) == 0)
                        send_word(ssa_pkg::MODE_ACQUIRE,
                                  ssa_pkg::SLOT_W'($urandom_range(63)));
                    else
                        send_word(ssa_pkg::MODE_RELEASE, in_range_index());
                end
            end else if (kind < 75) begin
                n = $urandom_range(60, 70);
                repeat (n) send_word(ssa_pkg::MODE_RELEASE, in_range_index());
            end else if (kind < 84) begin
                send_word(($urandom_range(1) == 0) ? MODE_CLEAR : MODE_CLEAR_ALT,
                          ssa_pkg::SLOT_W'($urandom_range(63)));
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) send_word(ssa_pkg::MODE_W'($urandom_range(3)),
                                     ssa_pkg::SLOT_W'($urandom_range(63)));
            end
        end
    endtask

    // Reset, directed words, then random phases over several limits
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_mode      = ssa_pkg::MODE_ACQUIRE;
        i_slot_in   = '0;
        i_stall     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_cycles = 0;
        words_sent  = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset limit of 8
        set_idling(0, 0);
        send_word(ssa_pkg::MODE_ACQUIRE, 6'd0);
        send_word(ssa_pkg::MODE_ACQUIRE, 6'd63);
        send_word(ssa_pkg::MODE_RELEASE, 6'd1);
        send_word(ssa_pkg::MODE_RELEASE, 6'd1);        // same index freed twice
        send_word(ssa_pkg::MODE_ACQUIRE, 6'd0);
        send_word(ssa_pkg::MODE_ACQUIRE, 6'd0);
        send_word(ssa_pkg::MODE_RELEASE, 6'd63);       // far out of range
        send_word(ssa_pkg::MODE_RELEASE, 6'd8);        // just past the limit
        send_word(ssa_pkg::MODE_RELEASE, 6'd7);
        repeat (7) send_word(ssa_pkg::MODE_ACQUIRE, 6'd42);
        send_word(ssa_pkg::MODE_ACQUIRE, 6'd0);        // counter at the limit
        send_word(MODE_CLEAR_ALT, 6'd21);              // mode three clears too
        send_word(ssa_pkg::MODE_ACQUIRE, 6'd0);
        send_word(MODE_CLEAR, 6'd0);
        send_word(ssa_pkg::MODE_RELEASE, 6'd0);
        send_word(ssa_pkg::MODE_ACQUIRE, 6'd63);
        send_word(MODE_CLEAR, 6'd63);
        set_idling(21, 21);
        run_mix(60);
        drain();

        // Full range; hold off the receiver so the block backs up
        write_limit(7'd64);
        set_idling(0, 0);
        run_mix(50);
        hold_cycles = 300;
        run_mix(30);
        run_mix(40);
        repeat (6) send_word(ssa_pkg::MODE_RELEASE,
                             ssa_pkg::SLOT_W'($urandom_range(32, 63)));
        drain();

        // Lower the limit with entries still on the stack
        write_limit(7'd1);
        set_idling(64, 0);
        repeat (4) send_word(ssa_pkg::MODE_ACQUIRE,
                             ssa_pkg::SLOT_W'($urandom_range(63)));
        run_mix(90);
        drain();

        // Zero limit: nothing fresh, every release out of range
        write_limit(7'd0);
        set_idling(0, 64);
        run_mix(80);
        drain();

        // Limit beyond capacity, with a run of releases that fills the stack
        write_limit(7'd127);
        set_idling(21, 21);
        repeat (70) send_word(ssa_pkg::MODE_RELEASE,
                              ssa_pkg::SLOT_W'($urandom_range(63)));
        run_mix(60);
        drain();

        write_limit(7'd63);
        set_idling(64, 0);
        run_mix(100);
        drain();

        write_limit(ssa_pkg::LIMIT_W'($urandom_range(127)));
        set_idling(0, 64);
        run_mix(100);
        drain();

        write_limit(ssa_pkg::LIMIT_RESET);
        set_idling(0, 0);
        run_mix(50);
        set_idling(21, 21);
        run_mix(70);
        drain();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/ssa_pkg.sv
hw/rtl/ssa_stack_mem.sv
hw/rtl/ssa_out_reg.sv
hw/rtl/ssa_ctrl.sv
hw/rtl/shadow_slot_allocator.sv
tb/sv/tb_shadow_slot_allocator.sv
